[hw/rtl/mhpq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants shared by the max-heap priority queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = CNT_W + 1;
    localparam int OCC_W    = 7;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_EXT,
        S_DN,
        S_DONE
    } t_heap_state;

    typedef struct packed {
        logic        command;
        logic [15:0] priority_req;
        logic [15:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [15:0]      out_priority;
        logic [15:0]      out_tag;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [15:0] prio;
        logic [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage
`default_nettype wire

[hw/rtl/mhpq_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_core
// Heap store and sequencer: sift-up on insert, sift-down on extract.
// ----------------------------------------------------------------------------
module mhpq_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  mhpq_pkg::t_in_item    i_item,
    input  wire                   i_ack,
    output mhpq_pkg::t_core_stat  o_stat,
    output mhpq_pkg::t_out_item   o_result
);

    localparam int ADDR_W = mhpq_pkg::ADDR_W;
    localparam int CNT_W  = mhpq_pkg::CNT_W;
    localparam int IDX_W  = mhpq_pkg::IDX_W;

    mhpq_pkg::t_entry r_mem [mhpq_pkg::CAPACITY];
    mhpq_pkg::t_entry r_rd_a;
    mhpq_pkg::t_entry r_rd_b;

    mhpq_pkg::t_heap_state r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    mhpq_pkg::t_entry      r_cur, n_cur;
    logic [15:0]           r_res_prio, n_res_prio;
    logic [15:0]           r_res_tag, n_res_tag;
    mhpq_pkg::t_status     r_status, n_status;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_wa;
    mhpq_pkg::t_entry      w_wd;
    logic [ADDR_W-1:0]     w_ra_a;
    logic [ADDR_W-1:0]     w_ra_b;

    logic [ADDR_W-1:0]     w_par;
    logic [IDX_W-1:0]      w_left;
    logic [IDX_W-1:0]      w_right;
    logic                  w_pick_l;
    logic                  w_pick_r;
    logic [15:0]           w_best_prio;
    logic [ADDR_W-1:0]     w_child;
    logic [IDX_W-1:0]      w_child_l;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_a <= r_mem[w_ra_a];
        r_rd_b <= r_mem[w_ra_b];
    end

    assign w_par       = ADDR_W'((r_pos - 1'b1) >> 1);
    assign w_left      = (IDX_W'(r_pos) << 1) + IDX_W'(1);
    assign w_right     = (IDX_W'(r_pos) << 1) + IDX_W'(2);
    assign w_pick_l    = (w_left < IDX_W'(r_count)) && (r_rd_a.prio > r_cur.prio);
    assign w_best_prio = w_pick_l ? r_rd_a.prio : r_cur.prio;
    assign w_pick_r    = (w_right < IDX_W'(r_count)) && (r_rd_b.prio > w_best_prio);
    assign w_child     = w_pick_r ? w_right[ADDR_W-1:0] : w_left[ADDR_W-1:0];
    assign w_child_l   = (IDX_W'(w_child) << 1) + IDX_W'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_res_prio = r_res_prio;
        n_res_tag  = r_res_tag;
        n_status   = r_status;
        w_we       = 1'b0;
        w_wa       = r_pos;
        w_wd       = r_cur;
        w_ra_a     = w_par;
        w_ra_b     = w_par;
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_res_prio = '0;
                    n_res_tag  = '0;
                    n_status   = mhpq_pkg::ST_OK;
                    if (i_item.command == mhpq_pkg::CMD_INSERT) begin
                        if (r_count == CNT_W'(mhpq_pkg::CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_cur   = '{prio: i_item.priority_req, tag: i_item.tag};
                            n_pos   = r_count[ADDR_W-1:0];
                            w_ra_a  = ADDR_W'((r_count[ADDR_W-1:0] - 1'b1) >> 1);
                            if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_wa    = '0;
                                w_wd    = n_cur;
                                n_state = mhpq_pkg::S_DONE;
                            end else begin
                                n_state = mhpq_pkg::S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            n_count = r_count - 1'b1;
                            w_ra_a  = '0;
                            w_ra_b  = ADDR_W'(r_count - 1'b1);
                            n_state = mhpq_pkg::S_EXT;
                        end
                    end
                end
            end
            mhpq_pkg::S_UP: begin
                w_we = 1'b1;
                if (r_cur.prio > r_rd_a.prio) begin
                    w_wd   = r_rd_a;
                    n_pos  = w_par;
                    w_ra_a = ADDR_W'((w_par - 1'b1) >> 1);
                    if (w_par == '0) begin
                        n_state = mhpq_pkg::S_PUT;
                    end
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_PUT: begin
                w_we    = 1'b1;
                n_state = mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_EXT: begin
                n_res_prio = r_rd_a.prio;
                n_res_tag  = r_rd_a.tag;
                n_cur      = r_rd_b;
                n_pos      = '0;
                w_ra_a     = ADDR_W'(1);
                w_ra_b     = ADDR_W'(2);
                if (r_count == '0) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    n_state = mhpq_pkg::S_DN;
                end
            end
            mhpq_pkg::S_DN: begin
                w_we   = 1'b1;
                w_ra_a = w_child_l[ADDR_W-1:0];
                w_ra_b = ADDR_W'(w_child_l + IDX_W'(1));
                if (w_pick_r) begin
                    w_wd  = r_rd_b;
                    n_pos = w_child;
                end else if (w_pick_l) begin
                    w_wd  = r_rd_a;
                    n_pos = w_child;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (i_ack) begin
                    n_state = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_res_prio <= n_res_prio;
        r_res_tag  <= n_res_tag;
        r_status   <= n_status;
    end

    assign o_stat.idle           = (r_state == mhpq_pkg::S_IDLE);
    assign o_stat.done           = (r_state == mhpq_pkg::S_DONE);
    assign o_result.out_priority = r_res_prio;
    assign o_result.out_tag      = r_res_tag;
    assign o_result.status       = r_status;
    assign o_result.occupancy    = mhpq_pkg::OCC_W'(r_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(mhpq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::S_DONE || r_state == mhpq_pkg::S_EXT) |-> !w_we)
        else $error("heap write outside a sift step");

    a_ack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::S_DONE && i_ack) |=> (r_state == mhpq_pkg::S_IDLE))
        else $error("result transfer did not return to idle");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::S_IDLE && i_start &&
         i_item.command == mhpq_pkg::CMD_EXTRACT && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("extract did not shrink the heap by one");
`endif

endmodule
`default_nettype wire

[hw/rtl/max_heap_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue with insert and extract commands.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid, o_in_stall | i_in_item  (t_in_item)
// out     | output    | o_out_valid, i_out_stall | o_out_item (t_out_item)
//
// The sift loop costs one cycle per tree level, set by the heap memory read.
// One item is in work at a time; o_in_stall is high until its result is held.
// Reset empties the queue at once; the heap memory needs no clearing pass.
// The result register lets the next item start while the last result waits.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  mhpq_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output mhpq_pkg::t_out_item  o_out_item
);

    mhpq_pkg::t_core_stat w_stat;
    mhpq_pkg::t_out_item  w_result;
    logic                 w_load;
    logic                 r_out_valid, n_out_valid;
    mhpq_pkg::t_out_item  r_out_item;

    mhpq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && w_stat.idle),
        .i_item   (i_in_item),
        .i_ack    (w_load),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    assign w_load      = w_stat.done && (!r_out_valid || !i_out_stall);
    assign n_out_valid = w_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_load) begin
            r_out_item <= w_result;
        end
    end

    assign o_in_stall  = !w_stat.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[bench/tb_max_heap_priority_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap priority queue. A queue of pending
// commands feeds a clocked driver, and a clocked monitor compares every result
// transfer with a cycle-free heap predictor. Random phases lean toward filling,
// draining or mixing the heap, so it reaches both full and empty often. Both
// channels idle at random; long receiver holds start at 150 results, then every 600.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;

    typedef struct {
        mhpq_pkg::t_in_item item;
        int                 gap_after;
        bit                 drain_first;
    } t_cmd_slot;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    mhpq_pkg::t_in_item  in_item = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    mhpq_pkg::t_out_item out_item;

    t_cmd_slot           cmd_backlog[$];
    mhpq_pkg::t_out_item heap_replies[$];
    mhpq_pkg::t_entry    heap_mem[mhpq_pkg::CAPACITY];
    int                  heap_count = 0;

    int n_items = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_ins_ok = 0;
    int n_ins_full = 0;
    int n_ext_ok = 0;
    int n_ext_empty = 0;
    int peak_count = 0;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 150;
    int seg_left = 0;
    bit seg_stalled = 1'b0;

    max_heap_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic mhpq_pkg::t_out_item heap_operate(mhpq_pkg::t_in_item cmd);
        mhpq_pkg::t_out_item reply;
        mhpq_pkg::t_entry    tmp;
        int                  pos;
        int                  par;
        int                  best;
        int                  lft;
        int                  rgt;
        bit                  settled;
        reply = '0;
        reply.status = mhpq_pkg::ST_OK;
        if (cmd.command == mhpq_pkg::CMD_INSERT) begin
            if (heap_count >= mhpq_pkg::CAPACITY) begin
                reply.status = mhpq_pkg::ST_FULL;
                n_ins_full++;
            end else begin
                pos = heap_count;
                heap_mem[pos].prio = cmd.priority_req;
                heap_mem[pos].tag = cmd.tag;
                heap_count++;
                n_ins_ok++;
                settled = 1'b0;
                while (pos > 0 && !settled) begin
                    par = (pos - 1) / 2;
                    if (heap_mem[pos].prio > heap_mem[par].prio) begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[par];
                        heap_mem[par] = tmp;
                        pos = par;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                reply.status = mhpq_pkg::ST_EMPTY;
                n_ext_empty++;
            end else begin
                reply.out_priority = heap_mem[0].prio;
                reply.out_tag = heap_mem[0].tag;
                heap_count--;
                n_ext_ok++;
                heap_mem[0] = heap_mem[heap_count];
                pos = 0;
                settled = 1'b0;
                while (!settled) begin
                    best = pos;
                    lft = 2 * pos + 1;
                    rgt = 2 * pos + 2;
                    if (lft < heap_count && heap_mem[lft].prio > heap_mem[best].prio)
                        best = lft;
                    if (rgt < heap_count && heap_mem[rgt].prio > heap_mem[best].prio)
                        best = rgt;
                    if (best == pos) begin
                        settled = 1'b1;
                    end else begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[best];
                        heap_mem[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        if (heap_count > peak_count)
            peak_count = heap_count;
        reply.occupancy = heap_count[mhpq_pkg::OCC_W-1:0];
        return reply;
    endfunction

    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 7));
            5: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic queue_cmd(logic cmd, logic [15:0] prio, logic [15:0] tag,
                             int gap, bit drain);
        t_cmd_slot slot;
        slot.item.command = cmd;
        slot.item.priority_req = prio;
        slot.item.tag = tag;
        slot.gap_after = gap;
        slot.drain_first = drain;
        cmd_backlog.push_back(slot);
        n_items++;
    endtask

    always @(posedge i_clk) begin
        t_cmd_slot nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                heap_replies.push_back(heap_operate(in_item));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() == 0 ||
                             (cmd_backlog[0].drain_first && heap_replies.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    nxt = cmd_backlog.pop_front();
                    in_item <= nxt.item;
                    in_valid <= 1'b1;
                    gap_left = nxt.gap_after;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        mhpq_pkg::t_out_item want;
        logic                nxt_stall;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (heap_replies.size() == 0) begin
                    $error("result transfer with no result pending");
                    n_errors++;
                end else begin
                    want = heap_replies.pop_front();
                    n_checked++;
                    if (out_item.out_priority !== want.out_priority) begin
                        $error("out_priority: expected %0d, actual %0d",
                               want.out_priority, out_item.out_priority);
                        n_errors++;
                    end
                    if (out_item.out_tag !== want.out_tag) begin
                        $error("out_tag: expected %0d, actual %0d",
                               want.out_tag, out_item.out_tag);
                        n_errors++;
                    end
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_item.status);
                        n_errors++;
                    end
                    if (out_item.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               want.occupancy, out_item.occupancy);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (n_checked >= next_hold_at) begin
                hold_left = 400;
                next_hold_at += 600;
                nxt_stall = 1'b1;
            end else if (seg_left > 0) begin
                seg_left--;
                nxt_stall = seg_stalled;
            end else begin
                if (seg_stalled || (n_checked % 400) < 60) begin
                    seg_stalled = 1'b0;
                    seg_left = $urandom_range(1, 30);
                end else begin
                    seg_stalled = 1'b1;
                    case ($urandom_range(0, 19))
                        0: seg_left = $urandom_range(20, 60);
                        1, 2, 3, 4, 5: seg_left = $urandom_range(4, 10);
                        default: seg_left = $urandom_range(1, 3);
                    endcase
                end
                nxt_stall = seg_stalled;
            end
            out_stall <= nxt_stall;
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", heap_replies.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int   ins_pct;
        int   plen;
        int   phase;
        bit   quiet;
        logic cmd;
        // Empty extract, extreme keys, ties among equal keys, then drain past empty.
        queue_cmd(mhpq_pkg::CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'h0000, 16'h0000, 0, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 1, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'h8000, 16'hAAAA, 0, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'h8000, 16'h5555, 2, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'h8000, 16'h1234, 0, 1'b0);
        queue_cmd(mhpq_pkg::CMD_INSERT, 16'h0001, 16'hFFFF, 0, 1'b0);
        for (int k = 0; k < 7; k++)
            queue_cmd(mhpq_pkg::CMD_EXTRACT, 16'($urandom), 16'($urandom), k % 2, 1'b0);
        for (int k = 1; k <= 5; k++)
            queue_cmd(mhpq_pkg::CMD_INSERT, 16'h7FFF, 16'(k), 0, 1'b0);
        for (int k = 0; k < 5; k++)
            queue_cmd(mhpq_pkg::CMD_EXTRACT, 16'h0000, 16'h0000, 0, 1'b0);

        phase = 0;
        while (n_items < 1250) begin
            case ($urandom_range(0, 2))
                0: ins_pct = 85;
                1: ins_pct = 15;
                default: ins_pct = 50;
            endcase
            plen = $urandom_range(20, 120);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < plen; k++) begin
                cmd = ($urandom_range(1, 100) <= ins_pct) ? mhpq_pkg::CMD_INSERT
                                                          : mhpq_pkg::CMD_EXTRACT;
                queue_cmd(cmd, pick_priority(), 16'($urandom), pick_gap(quiet),
                          (k == 0) && (phase % 4 == 1));
            end
            phase++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < n_items || heap_replies.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Ran %0d commands: %0d inserts, %0d refused full, %0d extracts, %0d refused empty",
                 n_accepted, n_ins_ok, n_ins_full, n_ext_ok, n_ext_empty);
        $display("Peak occupancy %0d of %0d, %0d results compared", peak_count,
                 mhpq_pkg::CAPACITY, n_checked);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_core.sv
hw/rtl/max_heap_priority_queue.sv
bench/tb_max_heap_priority_queue.sv
